FILE: design/bdc_pkg.sv
// Shared widths, constants, command/status types and calendar tables for the business day counter.
package bdc_pkg;

	localparam int DAY_W      = 5;
	localparam int MON_W      = 4;
	localparam int YEAR_W     = 14;
	localparam int ZY_W       = 15;   // year + 400, up to 16783
	localparam int CENT_W     = 8;    // (year + 400) / 100, up to 167
	localparam int SER_W      = 23;   // serial day number, below 2**23
	localparam int DVS_W      = 7;    // remainder width
	localparam int WD_W       = 3;
	localparam int CNT_W      = 16;
	localparam int TOT_W      = SER_W + 3;
	localparam int MOFF_W     = 9;

	// Reciprocals for exact division of any SER_W-bit value: q = (n * RECIP) >> SH
	localparam int RECIP_W          = 24;
	localparam int PROD_W           = SER_W + RECIP_W;
	localparam int RECIP_WEEK       = 9586981;    // ceil(2**26 / 7)
	localparam int RECIP_WEEK_SH    = 26;
	localparam int RECIP_CENTURY    = 10737419;   // ceil(2**30 / 100)
	localparam int RECIP_CENTURY_SH = 30;

	localparam int YEAR_SHIFT    = 400;
	localparam int DAYS_PER_YEAR = 365;
	localparam int CENTURY       = 100;
	localparam int WEEK          = 7;
	localparam int WORKDAYS      = 5;
	localparam int WEEKDAY_BIAS  = 3;   // weekday = (serial + 3) mod 7
	localparam int MONTHS        = 12;
	localparam int MARCH_SHIFT   = 9;
	localparam int LAST_JAN_FEB  = 2;
	localparam int COUNT_MAX     = 65535;

	// Divider operand selection
	typedef enum logic [2:0] {
		SEL_ZF,   // from year + 400 by 100
		SEL_ZT,   // to year + 400 by 100
		SEL_WF,   // from serial + bias by 7
		SEL_WT,   // to serial + bias by 7
		SEL_LEN   // range length by 7
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_go;
		logic     div_store;
		div_sel_t div_sel;
		logic     ser_a;
		logic     ser_b;
		logic     ser_to;
		logic     finish;
	} bdc_cmd_t;

	typedef struct packed {
		logic div_done;
		logic ordered;
	} bdc_status_t;

	// Days in month; zero for a month code outside 1..12.
	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
			4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
			4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
			default:                                    len = '0;
		endcase
		return len;
	endfunction

	// Days before month mp of a March-based year: (153 * mp + 2) / 5.
	function automatic logic [MOFF_W-1:0] month_offset(input logic [MON_W-1:0] mp);
		logic [MOFF_W-1:0] off;
		case (mp)
			4'd0:    off = MOFF_W'(0);
			4'd1:    off = MOFF_W'(31);
			4'd2:    off = MOFF_W'(61);
			4'd3:    off = MOFF_W'(92);
			4'd4:    off = MOFF_W'(122);
			4'd5:    off = MOFF_W'(153);
			4'd6:    off = MOFF_W'(184);
			4'd7:    off = MOFF_W'(214);
			4'd8:    off = MOFF_W'(245);
			4'd9:    off = MOFF_W'(275);
			4'd10:   off = MOFF_W'(306);
			4'd11:   off = MOFF_W'(337);
			default: off = '0;
		endcase
		return off;
	endfunction

	// Working days among the first rem days of a partial week starting on weekday fw.
	function automatic logic [WD_W-1:0] weekday_extra(input logic [WD_W-1:0] fw,
			input logic [WD_W-1:0] rem);
		logic [WD_W-1:0] cnt;
		logic [WD_W:0]   s;
		cnt = '0;
		for (int i = 0; i < WEEK - 1; i++) begin
			s = (WD_W+1)'(fw) + (WD_W+1)'(i);
			if (s >= (WD_W+1)'(WEEK))
				s = s - (WD_W+1)'(WEEK);
			if ((WD_W'(i) < rem) && (s < (WD_W+1)'(WORKDAYS)))
				cnt = cnt + WD_W'(1);
		end
		return cnt;
	endfunction

endpackage

FILE: design/bdc_divider.sv
// Divider by 7 or 100 through reciprocal multiplication, a short pipeline from go to done.
module bdc_divider import bdc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [SER_W-1:0] dividend,
	input  logic             by_century,
	output logic             done,
	output logic [SER_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);

	logic               v_s1;
	logic               v_s2;
	logic               done_q;
	logic               cent_q;
	logic [SER_W-1:0]   num_q;
	logic [PROD_W-1:0]  prod_s2;
	logic [SER_W-1:0]   quo_q;
	logic [DVS_W-1:0]   rem_q;
	logic [RECIP_W-1:0] recip;
	logic [SER_W-1:0]   quo;
	logic [SER_W-1:0]   back;
	logic [SER_W-1:0]   diff;

	assign recip = cent_q ? RECIP_W'(RECIP_CENTURY) : RECIP_W'(RECIP_WEEK);
	assign quo   = cent_q ? SER_W'(prod_s2 >> RECIP_CENTURY_SH) : SER_W'(prod_s2 >> RECIP_WEEK_SH);
	assign back  = cent_q ? quo * SER_W'(CENTURY) : quo * SER_W'(WEEK);
	assign diff  = num_q - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= go;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	// Hold the operand, multiply by the reciprocal, then take the remainder.
	always_ff @(posedge clk) begin
		if (go) begin
			num_q  <= dividend;
			cent_q <= by_century;
		end
		if (v_s1)
			prod_s2 <= PROD_W'(num_q) * PROD_W'(recip);
		if (v_s2) begin
			quo_q <= quo;
			rem_q <= diff[DVS_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: design/bdc_datapath.sv
// Datapath: operand registers, serial day numbers, shared divider and result registers.
module bdc_datapath import bdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  bdc_cmd_t          cmd,
	output bdc_status_t       status,
	input  logic [DAY_W-1:0]  from_day,
	input  logic [MON_W-1:0]  from_month,
	input  logic [YEAR_W-1:0] from_year,
	input  logic [DAY_W-1:0]  to_day,
	input  logic [MON_W-1:0]  to_month,
	input  logic [YEAR_W-1:0] to_year,
	output logic              done,
	output logic [CNT_W-1:0]  business_days,
	output logic              count_saturated,
	output logic              invalid_date,
	output logic [WD_W-1:0]   from_weekday,
	output logic [WD_W-1:0]   to_weekday
);

	logic [DAY_W-1:0]  fd_q, td_q;
	logic [MON_W-1:0]  fm_q, tm_q;
	logic [YEAR_W-1:0] fy_q, ty_q;
	logic [CENT_W-1:0] qf_q, qt_q;
	logic [DVS_W-1:0]  rf_q, rt_q;
	logic [SER_W-1:0]  prod_q, addend_q, nf_q, nt_q, q7_q;
	logic              vf_q, vt_q;
	logic [WD_W-1:0]   wf_q, wt_q, r7_q;
	logic              done_q;
	logic [CNT_W-1:0]  days_q;
	logic              sat_q, inval_q;
	logic [WD_W-1:0]   fwd_q, twd_q;

	// Divider hookup
	logic [SER_W-1:0]  div_dividend, div_quo;
	logic [DVS_W-1:0]  div_rem;
	logic              div_century;
	logic              div_done;

	// Serial number of the selected date
	logic [DAY_W-1:0]  sd;
	logic [MON_W-1:0]  sm;
	logic [YEAR_W-1:0] sy;
	logic [CENT_W-1:0] sq;
	logic [DVS_W-1:0]  sr;
	logic [ZY_W-1:0]   z, yy;
	logic              jan_feb, r_zero, leap, valid;
	logic [CENT_W-1:0] c100, c400;
	logic [MON_W:0]    mp_raw;
	logic [MON_W-1:0]  mp;

	logic [TOT_W-1:0]  total;

	bdc_divider u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (cmd.div_go),
		.dividend   (div_dividend),
		.by_century (div_century),
		.done       (div_done),
		.quotient   (div_quo),
		.remainder  (div_rem)
	);

	always_comb begin
		div_century = 1'b0;
		case (cmd.div_sel)
			SEL_ZF: begin
				div_dividend = SER_W'(fy_q) + SER_W'(YEAR_SHIFT);
				div_century  = 1'b1;
			end
			SEL_ZT: begin
				div_dividend = SER_W'(ty_q) + SER_W'(YEAR_SHIFT);
				div_century  = 1'b1;
			end
			SEL_WF:  div_dividend = nf_q + SER_W'(WEEKDAY_BIAS);
			SEL_WT:  div_dividend = nt_q + SER_W'(WEEKDAY_BIAS);
			SEL_LEN: div_dividend = nt_q - nf_q;
			default: div_dividend = '0;
		endcase
	end

	always_comb begin
		sd      = cmd.ser_to ? td_q : fd_q;
		sm      = cmd.ser_to ? tm_q : fm_q;
		sy      = cmd.ser_to ? ty_q : fy_q;
		sq      = cmd.ser_to ? qt_q : qf_q;
		sr      = cmd.ser_to ? rt_q : rf_q;
		z       = ZY_W'(sy) + ZY_W'(YEAR_SHIFT);
		jan_feb = sm <= MON_W'(LAST_JAN_FEB);
		r_zero  = sr == '0;
		yy      = z - ZY_W'(jan_feb);
		c100    = sq - CENT_W'(jan_feb && r_zero);
		c400    = c100 >> 2;
		// z is congruent to the year mod 400, and z / 100 mod 4 tracks year / 100 mod 4
		leap    = ((z[1:0] == 2'b00) && !r_zero) || (r_zero && (sq[1:0] == 2'b00));
		valid   = (sm >= MON_W'(1)) && (sm <= MON_W'(MONTHS)) && (sd != '0)
		          && (sd <= month_len(sm, leap));
		mp_raw  = (MON_W+1)'(sm) + (MON_W+1)'(MARCH_SHIFT);
		if (mp_raw >= (MON_W+1)'(MONTHS))
			mp_raw = mp_raw - (MON_W+1)'(MONTHS);
		mp      = mp_raw[MON_W-1:0];
	end

	assign status.div_done = div_done;
	assign status.ordered  = vf_q && vt_q && (nf_q < nt_q);

	assign total = (TOT_W'(q7_q) << 2) + TOT_W'(q7_q) + TOT_W'(weekday_extra(wf_q, r7_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fd_q <= from_day;
			fm_q <= from_month;
			fy_q <= from_year;
			td_q <= to_day;
			tm_q <= to_month;
			ty_q <= to_year;
		end
		if (cmd.div_store) begin
			case (cmd.div_sel)
				SEL_ZF: begin
					qf_q <= div_quo[CENT_W-1:0];
					rf_q <= div_rem;
				end
				SEL_ZT: begin
					qt_q <= div_quo[CENT_W-1:0];
					rt_q <= div_rem;
				end
				SEL_WF: wf_q <= div_rem[WD_W-1:0];
				SEL_WT: wt_q <= div_rem[WD_W-1:0];
				SEL_LEN: begin
					q7_q <= div_quo;
					r7_q <= div_rem[WD_W-1:0];
				end
				default: ;
			endcase
		end
		if (cmd.ser_a) begin
			prod_q   <= SER_W'(yy) * SER_W'(DAYS_PER_YEAR);
			addend_q <= SER_W'(yy >> 2) - SER_W'(c100) + SER_W'(c400)
			            + SER_W'(month_offset(mp)) + SER_W'(sd) - SER_W'(1);
			if (cmd.ser_to)
				vt_q <= valid;
			else
				vf_q <= valid;
		end
		if (cmd.ser_b) begin
			if (cmd.ser_to)
				nt_q <= prod_q + addend_q;
			else
				nf_q <= prod_q + addend_q;
		end
		if (cmd.finish) begin
			inval_q <= !(vf_q && vt_q);
			fwd_q   <= vf_q ? wf_q : '0;
			twd_q   <= vt_q ? wt_q : '0;
			if (!status.ordered) begin
				days_q <= '0;
				sat_q  <= 1'b0;
			end else if (total > TOT_W'(COUNT_MAX)) begin
				days_q <= CNT_W'(COUNT_MAX);
				sat_q  <= 1'b1;
			end else begin
				days_q <= total[CNT_W-1:0];
				sat_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.finish;
	end

	assign done            = done_q;
	assign business_days   = days_q;
	assign count_saturated = sat_q;
	assign invalid_date    = inval_q;
	assign from_weekday    = fwd_q;
	assign to_weekday      = twd_q;

endmodule

FILE: design/bdc_ctrl.sv
// Controller state machine sequencing divisions and serial-number steps.
module bdc_ctrl import bdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  bdc_status_t status,
	output bdc_cmd_t    cmd,
	output logic        busy
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DZF_GO = 5'd1;
	localparam logic [4:0] S_DZF_W  = 5'd2;
	localparam logic [4:0] S_DZT_GO = 5'd3;
	localparam logic [4:0] S_DZT_W  = 5'd4;
	localparam logic [4:0] S_SF_A   = 5'd5;
	localparam logic [4:0] S_SF_B   = 5'd6;
	localparam logic [4:0] S_ST_A   = 5'd7;
	localparam logic [4:0] S_ST_B   = 5'd8;
	localparam logic [4:0] S_DWF_GO = 5'd9;
	localparam logic [4:0] S_DWF_W  = 5'd10;
	localparam logic [4:0] S_DWT_GO = 5'd11;
	localparam logic [4:0] S_DWT_W  = 5'd12;
	localparam logic [4:0] S_CHK    = 5'd13;
	localparam logic [4:0] S_DL_GO  = 5'd14;
	localparam logic [4:0] S_DL_W   = 5'd15;
	localparam logic [4:0] S_FIN    = 5'd16;

	logic [4:0] state_q, state_d;

	always_comb begin
		cmd     = '0;
		cmd.div_sel = SEL_ZF;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DZF_GO;
				end
			end
			S_DZF_GO: begin
				cmd.div_go = 1'b1;
				state_d    = S_DZF_W;
			end
			S_DZF_W: begin
				cmd.div_store = status.div_done;
				if (status.div_done)
					state_d = S_DZT_GO;
			end
			S_DZT_GO: begin
				cmd.div_sel = SEL_ZT;
				cmd.div_go  = 1'b1;
				state_d     = S_DZT_W;
			end
			S_DZT_W: begin
				cmd.div_sel   = SEL_ZT;
				cmd.div_store = status.div_done;
				if (status.div_done)
					state_d = S_SF_A;
			end
			S_SF_A: begin
				cmd.ser_a = 1'b1;
				state_d   = S_SF_B;
			end
			S_SF_B: begin
				cmd.ser_b = 1'b1;
				state_d   = S_ST_A;
			end
			S_ST_A: begin
				cmd.ser_a  = 1'b1;
				cmd.ser_to = 1'b1;
				state_d    = S_ST_B;
			end
			S_ST_B: begin
				cmd.ser_b  = 1'b1;
				cmd.ser_to = 1'b1;
				state_d    = S_DWF_GO;
			end
			S_DWF_GO: begin
				cmd.div_sel = SEL_WF;
				cmd.div_go  = 1'b1;
				state_d     = S_DWF_W;
			end
			S_DWF_W: begin
				cmd.div_sel   = SEL_WF;
				cmd.div_store = status.div_done;
				if (status.div_done)
					state_d = S_DWT_GO;
			end
			S_DWT_GO: begin
				cmd.div_sel = SEL_WT;
				cmd.div_go  = 1'b1;
				state_d     = S_DWT_W;
			end
			S_DWT_W: begin
				cmd.div_sel   = SEL_WT;
				cmd.div_store = status.div_done;
				if (status.div_done)
					state_d = S_CHK;
			end
			S_CHK: begin
				state_d = status.ordered ? S_DL_GO : S_FIN;
			end
			S_DL_GO: begin
				cmd.div_sel = SEL_LEN;
				cmd.div_go  = 1'b1;
				state_d     = S_DL_W;
			end
			S_DL_W: begin
				cmd.div_sel   = SEL_LEN;
				cmd.div_store = status.div_done;
				if (status.div_done)
					state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = state_q != S_IDLE;

endmodule

FILE: design/business_day_counter_top.sv
// Top level of the business day counter: controller plus datapath.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------------------
//  request   | start / busy       | from_day, from_month, from_year, to_day, to_month,
//            |                    | to_year
//  result    | done (1-cycle)     | business_days, count_saturated, invalid_date,
//            |                    | from_weekday, to_weekday
//
// A transaction is accepted on a clock edge with start high and busy low. busy then
// stays high through the steps below, which run longer when both dates are valid and
// start is before end; the result shows in the first cycle with busy low, with done
// high for that one cycle. The steps are set by the shared constant divider: each
// division runs through launch, reciprocal multiply, remainder and store; there are five
// divisions (two by 100, three by 7) with the range-length one skipped for empty or
// invalid requests, plus two serial-number steps per date, one range check and one
// capture step. The receiver cannot stall: results are taken as shown, and a new
// request may be accepted in the same cycle that done is high.
// arst_n clears the controller, divider control and the done strobe; no warm-up pass.
//
// Method: each date maps to a serial day number (March-based year shifted by 400);
// weekday = (serial + 3) mod 7, and the count is 5 per whole week plus a small
// table lookup for the partial week.
module business_day_counter_top import bdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [DAY_W-1:0]  from_day,
	input  logic [MON_W-1:0]  from_month,
	input  logic [YEAR_W-1:0] from_year,
	input  logic [DAY_W-1:0]  to_day,
	input  logic [MON_W-1:0]  to_month,
	input  logic [YEAR_W-1:0] to_year,
	output logic              done,
	output logic [CNT_W-1:0]  business_days,
	output logic              count_saturated,
	output logic              invalid_date,
	output logic [WD_W-1:0]   from_weekday,
	output logic [WD_W-1:0]   to_weekday
);

	bdc_cmd_t    cmd;
	bdc_status_t status;

	// Sequence the transaction: operand load, divisions, serial steps, result capture
	bdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Hold operands and intermediate numbers; drive the result registers
	bdc_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.from_day        (from_day),
		.from_month      (from_month),
		.from_year       (from_year),
		.to_day          (to_day),
		.to_month        (to_month),
		.to_year         (to_year),
		.done            (done),
		.business_days   (business_days),
		.count_saturated (count_saturated),
		.invalid_date    (invalid_date),
		.from_weekday    (from_weekday),
		.to_weekday      (to_weekday)
	);

	// A result strobe always closes a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $fell(busy))
		else $error("result strobe without a finished transaction");

	// An accepted request starts work on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not start");

	// Saturation flag only with the clamped count
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && count_saturated) |-> (business_days == CNT_W'(COUNT_MAX)))
		else $error("saturation flag with unclamped count");

	// Invalid dates give an empty count
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && invalid_date) |-> (business_days == '0 && !count_saturated))
		else $error("count reported for an invalid date");

	// Weekdays stay in 0..6
	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (from_weekday != 3'd7 && to_weekday != 3'd7))
		else $error("weekday out of range");

endmodule
